// ===== rtl/core/rasr_pkg.sv =====
// Shared types and constants for the rational add/subtract/reduce block.
`timescale 1ns / 1ps

package rasr_pkg;

    localparam int MAG_BITS_DEF = 31;   // default magnitude width
    localparam int FIELD_W      = 31;   // operand field width on the ports
    localparam int OUT_W        = 63;   // result field width on the ports
    localparam int QUEUE_DEPTH  = 2;    // jobs held between front and back

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] a_numerator;
        logic [FIELD_W-1:0] a_denominator;
        logic               a_negative;
        logic [FIELD_W-1:0] b_numerator;
        logic [FIELD_W-1:0] b_denominator;
        logic               b_negative;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] result_numerator;
        logic [OUT_W-1:0] result_denominator;
        logic             result_negative;
    } t_out;

    // Classified job: masked magnitudes and effective signs
    typedef struct packed {
        logic               same_sign;
        logic               a_neg;
        logic               b_neg;
        logic [FIELD_W-1:0] an;
        logic [FIELD_W-1:0] ad;
        logic [FIELD_W-1:0] bn;
        logic [FIELD_W-1:0] bd;
    } t_job;

endpackage

// ===== rtl/core/rasr_front.sv =====
// Front end: input handshake, magnitude masking and sign classification.
`timescale 1ns / 1ps

module rasr_front #(
    parameter int MAG_BITS = rasr_pkg::MAG_BITS_DEF
) (
    input  logic           i_valid,
    output logic           o_stall,
    input  rasr_pkg::t_in  i_in,
    input  logic           i_queue_full,
    output logic           o_push,
    output rasr_pkg::t_job o_job
);
    import rasr_pkg::*;

    localparam logic [FIELD_W-1:0] MASK = FIELD_W'((64'd1 << MAG_BITS) - 64'd1);

    logic b_eff_neg;

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // subtract is add with the second sign flipped
    assign b_eff_neg = i_in.b_negative ^ i_in.action;

    always_comb begin
        o_job.same_sign = (i_in.a_negative == b_eff_neg);
        o_job.a_neg     = i_in.a_negative;
        o_job.b_neg     = b_eff_neg;
        o_job.an        = i_in.a_numerator   & MASK;
        o_job.ad        = i_in.a_denominator & MASK;
        o_job.bn        = i_in.b_numerator   & MASK;
        o_job.bd        = i_in.b_denominator & MASK;
    end

endmodule

// ===== rtl/core/rasr_queue.sv =====
// Short job queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module rasr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rasr_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output rasr_pkg::t_job o_job
);
    import rasr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/rasr_back.sv =====
// Back end: shared multiplier, add/subtract, binary gcd, shared divider, output register.
`timescale 1ns / 1ps

module rasr_back #(
    parameter int MAG_BITS = rasr_pkg::MAG_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  rasr_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_busy,
    output logic           o_valid,
    input  logic           i_stall,
    output rasr_pkg::t_out o_out
);
    import rasr_pkg::*;

    localparam int PW = 2 * MAG_BITS;   // product width
    localparam int NW = PW + 1;         // numerator width after the add
    localparam int CW = $clog2(NW);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_COMB = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_DIVN = 7'b0010000,
        S_DIVD = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [1:0]        r_mcnt;
    logic [PW-1:0]     r_p1;
    logic [PW-1:0]     r_p2;
    logic [PW-1:0]     r_den;
    logic [NW-1:0]     r_u;
    logic [NW-1:0]     r_v;
    logic [NW-1:0]     r_num;
    logic [NW-1:0]     r_dn;
    logic [NW-1:0]     r_g;
    logic [NW-1:0]     r_dvd;
    logic [NW-1:0]     r_rem;
    logic [NW-1:0]     r_qnum;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic              r_out_valid;
    t_out              r_out;

    logic [MAG_BITS-1:0] m_x;
    logic [MAG_BITS-1:0] m_y;
    logic [PW-1:0]       n_prod;
    logic [NW-1:0]       n_sum;
    logic                n_neg;
    logic [NW:0]         n_trial;
    logic                n_ge;
    logic [NW:0]         n_rem;
    logic [NW-1:0]       n_dvd;
    logic                out_free;

    assign o_pop    = (r_state == S_IDLE) && i_job_valid;
    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;
    assign out_free = !r_out_valid || !i_stall;

    // one multiplier, three products in turn
    always_comb begin
        case (r_mcnt)
            2'd0: begin
                m_x = r_job.an[MAG_BITS-1:0];
                m_y = r_job.bd[MAG_BITS-1:0];
            end
            2'd1: begin
                m_x = r_job.bn[MAG_BITS-1:0];
                m_y = r_job.ad[MAG_BITS-1:0];
            end
            default: begin
                m_x = r_job.ad[MAG_BITS-1:0];
                m_y = r_job.bd[MAG_BITS-1:0];
            end
        endcase
        n_prod = PW'(m_x) * PW'(m_y);
    end

    // sign follows the larger term
    always_comb begin
        if (r_job.same_sign) begin
            n_sum = NW'(r_p1) + NW'(r_p2);
            n_neg = r_job.a_neg;
        end else if (r_p1 >= r_p2) begin
            n_sum = NW'(r_p1 - r_p2);
            n_neg = r_job.a_neg;
        end else begin
            n_sum = NW'(r_p2 - r_p1);
            n_neg = r_job.b_neg;
        end
    end

    // restoring divider, one quotient bit a cycle
    always_comb begin
        n_trial = {r_rem, r_dvd[NW-1]};
        n_ge    = (n_trial >= {1'b0, r_g});
        n_rem   = n_ge ? (n_trial - {1'b0, r_g}) : n_trial;
        n_dvd   = {r_dvd[NW-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_mcnt  <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_mcnt)
                        2'd0:    r_p1 <= n_prod;
                        2'd1:    r_p2 <= n_prod;
                        default: r_den <= n_prod;
                    endcase
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd2) begin
                        r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    if (n_sum == '0) begin
                        // zero result: 0/1, positive
                        r_qnum  <= '0;
                        r_dvd   <= NW'(1);
                        r_neg   <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_u     <= n_sum;
                        r_v     <= NW'(r_den);
                        r_num   <= n_sum;
                        r_dn    <= NW'(r_den);
                        r_neg   <= n_neg;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_u == '0 || r_v == '0) begin
                        r_g     <= r_u | r_v;
                        r_dvd   <= r_num;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVN;
                    end else if (!r_u[0] && !r_v[0]) begin
                        // common factor two comes straight off num and den
                        r_u   <= r_u >> 1;
                        r_v   <= r_v >> 1;
                        r_num <= r_num >> 1;
                        r_dn  <= r_dn >> 1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u >= r_v) begin
                        r_u <= (r_u - r_v) >> 1;
                    end else begin
                        r_v <= (r_v - r_u) >> 1;
                    end
                end
                S_DIVN: begin
                    if (r_cnt == CW'(NW - 1)) begin
                        r_qnum  <= n_dvd;
                        r_dvd   <= r_dn;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVD;
                    end else begin
                        r_dvd <= n_dvd;
                        r_rem <= n_rem[NW-1:0];
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIVD: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem[NW-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NW - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.result_numerator   <= OUT_W'(r_qnum);
                        r_out.result_denominator <= OUT_W'(r_dvd);
                        r_out.result_negative    <= r_neg;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/rational_add_sub_reduce_top.sv =====
// Top level of the rational add/subtract/reduce block.
`timescale 1ns / 1ps

// Adds or subtracts two sign-magnitude fractions and returns the result reduced
// to lowest terms; a zero result comes out as 0/1, positive. Beats are taken
// into a two-entry queue at once, so the input side keeps moving while a
// result waits on the output register, until the queue is full. Each beat
// goes through the shared multiplier, the binary gcd loop and the shared
// divider, which runs over N = 2*MAG_BITS + 1 bits for the numerator and
// then the denominator; a zero result skips the gcd and divider. Beats are
// processed one at a time, in order.
module rational_add_sub_reduce_top #(
    parameter int MAG_BITS = rasr_pkg::MAG_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  rasr_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output rasr_pkg::t_out o_out
);
    import rasr_pkg::*;

    localparam int NW = 2 * MAG_BITS + 1;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job f_job;
    t_job q_job;
    logic back_busy;

    rasr_front #(
        .MAG_BITS (MAG_BITS)
    ) u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in         (i_in),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_job        (f_job)
    );

    rasr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    rasr_back #(
        .MAG_BITS (MAG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_busy      (back_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

    a_zero_canonical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.result_numerator == '0) |->
            (o_out.result_denominator == OUT_W'(1) && !o_out.result_negative))
        else $error("zero result not 0/1 positive");

    a_num_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out.result_numerator >> NW) == '0))
        else $error("result numerator wider than the sum width");

    a_result_from_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(back_busy))
        else $error("result appeared without back end work");

    a_pop_only_with_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_valid && !back_busy))
        else $error("job taken from empty queue or while busy");

endmodule

// ===== sim/rational_add_sub_reduce_top_tb.sv =====
// Self-checking testbench for the rational add/subtract/reduce block.
`timescale 1ns / 1ps

module rational_add_sub_reduce_top_tb;
    import rasr_pkg::*;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_SUB = 1'b1;
    localparam logic POS     = 1'b0;
    localparam logic NEG     = 1'b1;

    localparam int LIMIT_CYCLES = 20000;
    localparam int TAIL_CYCLES  = 400;
    localparam int N_RANDOM     = 1680;

    localparam logic [FIELD_W-1:0] MAG_MAX = '1;
    localparam logic [FIELD_W-1:0] MAG_M1  = MAG_MAX - 1'b1;

    typedef struct {
        t_in  stim;
        bit   typed;
        t_out want;
    } t_row;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_in    = '0;
    logic o_stall;
    logic o_valid;
    t_out o_out;

    int   send_idle_pct  = 38;
    int   recv_stall_pct = 66;
    int   n_errors       = 0;
    int   quiet_cycles   = 0;
    t_out fractions_due[$];
    t_row dir_rows[$];

    rational_add_sub_reduce_top #(
        .MAG_BITS (MAG_BITS_DEF)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sum or difference of the two fractions, reduced to lowest terms
    function automatic t_out rational_sum(input t_in x);
        logic [63:0] an, ad, bn, bd, p1, p2, num, den, u, v, r;
        logic        neg, b_eff;
        t_out        res;
        an    = 64'(x.a_numerator);
        ad    = 64'(x.a_denominator);
        bn    = 64'(x.b_numerator);
        bd    = 64'(x.b_denominator);
        b_eff = x.b_negative ^ (x.action == ACT_SUB);
        p1    = an * bd;
        p2    = bn * ad;
        den   = ad * bd;
        if (x.a_negative == b_eff) begin
            num = p1 + p2;
            neg = x.a_negative;
        end else if (p1 >= p2) begin
            num = p1 - p2;
            neg = x.a_negative;
        end else begin
            num = p2 - p1;
            neg = b_eff;
        end
        if (num == 0) begin
            den = 1;
            neg = POS;
        end else begin
            u = num;
            v = den;
            while (v != 0) begin
                r = u % v;
                u = v;
                v = r;
            end
            num = num / u;
            den = den / u;
        end
        res.result_numerator   = num[OUT_W-1:0];
        res.result_denominator = den[OUT_W-1:0];
        res.result_negative    = neg;
        return res;
    endfunction

    function automatic t_in frac_in(input logic act,
                                    input logic [FIELD_W-1:0] an, input logic [FIELD_W-1:0] ad,
                                    input logic a_neg,
                                    input logic [FIELD_W-1:0] bn, input logic [FIELD_W-1:0] bd,
                                    input logic b_neg);
        t_in x;
        x.action        = act;
        x.a_numerator   = an;
        x.a_denominator = ad;
        x.a_negative    = a_neg;
        x.b_numerator   = bn;
        x.b_denominator = bd;
        x.b_negative    = b_neg;
        return x;
    endfunction

    function automatic t_out frac_out(input logic [OUT_W-1:0] n, input logic [OUT_W-1:0] d,
                                      input logic neg);
        t_out y;
        y.result_numerator   = n;
        y.result_denominator = d;
        y.result_negative    = neg;
        return y;
    endfunction

    task automatic add_row(input t_in stim, input bit typed, input t_out want);
        t_row row;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Magnitude of random bit length, so small values turn up often
    function automatic logic [FIELD_W-1:0] rand_mag();
        logic [FIELD_W-1:0] v, m;
        int                 w;
        w = $urandom_range(FIELD_W, 1);
        v = FIELD_W'($urandom);
        m = '1;
        m = m >> (FIELD_W - w);
        return v & m;
    endfunction

    function automatic t_in rand_item();
        t_in x;
        int  kind;
        int  k;
        kind            = $urandom_range(99);
        x.action        = 1'($urandom_range(1));
        x.a_negative    = 1'($urandom_range(1));
        x.b_negative    = 1'($urandom_range(1));
        x.a_numerator   = rand_mag();
        x.a_denominator = rand_mag();
        x.b_numerator   = rand_mag();
        x.b_denominator = rand_mag();
        if (kind < 25) begin
            x.a_numerator   = FIELD_W'($urandom);
            x.a_denominator = FIELD_W'($urandom);
            x.b_numerator   = FIELD_W'($urandom);
            x.b_denominator = FIELD_W'($urandom);
        end else if (kind < 50) begin
            // common factors so the reduction has work to do
            k               = $urandom_range(64, 1);
            x.a_numerator   = FIELD_W'(k * $urandom_range(2000));
            x.a_denominator = FIELD_W'(k * $urandom_range(2000, 1));
            x.b_numerator   = FIELD_W'(k * $urandom_range(2000));
            x.b_denominator = FIELD_W'($urandom_range(64, 1) * $urandom_range(2000, 1));
        end else if (kind < 65) begin
            x.b_denominator = 1;
        end else if (kind < 78) begin
            // same value, opposite effective sign: cancels to zero
            k               = $urandom_range(1000, 1);
            x.a_numerator   = FIELD_W'($urandom_range(2 ** 20));
            x.a_denominator = FIELD_W'($urandom_range(2 ** 20, 1));
            x.b_numerator   = FIELD_W'(x.a_numerator * k);
            x.b_denominator = FIELD_W'(x.a_denominator * k);
            x.b_negative    = x.a_negative ^ (x.action == ACT_ADD);
        end else if (kind < 86) begin
            k = $urandom_range(2);
            if (k != 1) x.a_numerator = 0;
            if (k != 0) x.b_numerator = 0;
        end else begin
            x.a_numerator   = FIELD_W'(MAG_MAX - $urandom_range(15));
            x.a_denominator = FIELD_W'(MAG_MAX - $urandom_range(15));
            x.b_numerator   = FIELD_W'(MAG_MAX - $urandom_range(15));
            x.b_denominator = FIELD_W'(MAG_MAX - $urandom_range(15));
        end
        if (x.a_denominator == 0) x.a_denominator = 1;
        if (x.b_denominator == 0) x.b_denominator = 1;
        return x;
    endfunction

    // Drive one beat at the falling edge; hold it until taken
    task automatic push_beat(input t_in beat, input bit typed, input t_out want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= beat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        fractions_due.push_back(typed ? want : rational_sum(beat));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (fractions_due.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (fractions_due.size() == 0) begin
                $error("unexpected result %0d/%0d neg=%0b", o_out.result_numerator,
                       o_out.result_denominator, o_out.result_negative);
                n_errors++;
            end else begin
                want = fractions_due.pop_front();
                if (o_out.result_numerator !== want.result_numerator) begin
                    $error("result_numerator: expected %0d, got %0d",
                           want.result_numerator, o_out.result_numerator);
                    n_errors++;
                end
                if (o_out.result_denominator !== want.result_denominator) begin
                    $error("result_denominator: expected %0d, got %0d",
                           want.result_denominator, o_out.result_denominator);
                    n_errors++;
                end
                if (o_out.result_negative !== want.result_negative) begin
                    $error("result_negative: expected %0b, got %0b",
                           want.result_negative, o_out.result_negative);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: cycles without a beat on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= LIMIT_CYCLES) begin
            $display("rational_add_sub_reduce_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int i;
        add_row(frac_in(ACT_ADD, 0, 1, POS, 0, 1, POS), 1, frac_out(0, 1, POS));
        add_row(frac_in(ACT_ADD, 1, 2, POS, 1, 2, POS), 1, frac_out(1, 1, POS));
        add_row(frac_in(ACT_ADD, MAG_MAX, MAG_MAX, POS, MAG_MAX, MAG_MAX, POS), 1,
                frac_out(2, 1, POS));
        add_row(frac_in(ACT_SUB, MAG_MAX, 1, NEG, MAG_MAX, 1, NEG), 1, frac_out(0, 1, POS));
        add_row(frac_in(ACT_ADD, MAG_MAX, 1, POS, MAG_MAX, 1, POS), 1,
                frac_out(63'd4294967294, 1, POS));
        add_row(frac_in(ACT_ADD, 1, MAG_MAX, POS, 1, MAG_MAX, POS), 1,
                frac_out(2, OUT_W'(MAG_MAX), POS));
        add_row(frac_in(ACT_SUB, 1, 3, POS, 1, 2, POS), 1, frac_out(1, 6, NEG));
        add_row(frac_in(ACT_ADD, 1, 3, NEG, 1, 6, NEG), 1, frac_out(1, 2, NEG));
        // integer second operand
        add_row(frac_in(ACT_ADD, 3, 4, POS, 2, 1, NEG), 1, frac_out(5, 4, NEG));
        add_row(frac_in(ACT_SUB, 5, 2, POS, 3, 1, NEG), 1, frac_out(11, 2, POS));
        // negative zero comes out positive
        add_row(frac_in(ACT_ADD, 0, 5, NEG, 0, 7, NEG), 1, frac_out(0, 1, POS));
        // zero denominators: nonzero numerator reduces to 1/0
        add_row(frac_in(ACT_ADD, 3, 0, NEG, 1, 2, POS), 1, frac_out(1, 0, NEG));
        add_row(frac_in(ACT_ADD, 0, 0, POS, 0, 0, POS), 1, frac_out(0, 1, POS));
        add_row(frac_in(ACT_ADD, MAG_MAX, 1, NEG, MAG_MAX, 1, POS), 1, frac_out(0, 1, POS));
        add_row(frac_in(ACT_SUB, 1, 2, POS, 1, 3, NEG), 1, frac_out(5, 6, POS));
        add_row(frac_in(ACT_ADD, 2, 1, NEG, 1, 1, POS), 1, frac_out(1, 1, NEG));
        add_row(frac_in(ACT_SUB, 0, MAG_MAX, POS, MAG_MAX, 1, POS), 1,
                frac_out(OUT_W'(MAG_MAX), 1, NEG));
        add_row(frac_in(ACT_SUB, MAG_MAX, MAG_M1, POS, MAG_M1, MAG_MAX, POS), 0, '0);
        add_row(frac_in(ACT_ADD, 1, MAG_MAX, NEG, MAG_MAX, 1, POS), 0, '0);
        add_row(frac_in(ACT_ADD, 31'h2AAAAAAA, 31'h55555555, POS,
                        31'h55555555, 31'h2AAAAAAA, NEG), 0, '0);
        add_row(frac_in(ACT_SUB, MAG_MAX, 1, POS, 1, 1, POS), 0, '0);
        add_row(frac_in(ACT_SUB, 31'h12345678, 31'h0ABCDEF1, NEG,
                        31'h7EDCBA98, 31'h00000F0F, POS), 0, '0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[n]) push_beat(dir_rows[n].stim, dir_rows[n].typed, dir_rows[n].want);
        drain();

        for (i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                send_idle_pct  = 66;
                recv_stall_pct = 38;
            end
            if (i == 2 * N_RANDOM / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            push_beat(rand_item(), 1'b0, '0);
            if (i == N_RANDOM / 2) drain();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && fractions_due.size() == 0) begin
            $display("rational_add_sub_reduce_top_tb: done, clean");
        end else begin
            $display("rational_add_sub_reduce_top_tb: done, errors");
        end
        $finish;
    end

endmodule
